// ===== rtl/svcp_pkg.sv =====
`default_nettype none
package svcp_pkg;

   localparam int COORD_FRAC_BITS = 16;
   localparam int AXIS_FRAC       = 14;
   localparam int CLIP_FRAC       = 30;
   localparam int QUOT_BITS       = 16;
   localparam int SCREEN_SCALE    = 2500;
   localparam int CENTER_COL      = 1250;
   localparam int CENTER_ROW      = 700;
   localparam int X_LIMIT         = 25;
   localparam int Z_LIMIT         = 50;

   typedef enum logic [2:0] {
      REG_ORIGIN_X = 3'd0,
      REG_ORIGIN_Y = 3'd1,
      REG_ORIGIN_Z = 3'd2,
      REG_RIGHT    = 3'd3,
      REG_UP       = 3'd4,
      REG_FORWARD  = 3'd5,
      REG_NEAR     = 3'd6
   } csr_index_type;

   typedef logic signed [31:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } vec_type;

   typedef struct packed {
      coord_type   origin_x;
      coord_type   origin_y;
      coord_type   origin_z;
      logic [47:0] right_axis;
      logic [47:0] up_axis;
      logic [47:0] forward_axis;
      logic [30:0] near_plane;
   } cfg_type;

   typedef struct packed {
      vec_type a;
      vec_type b;
      logic    vis;
      logic    last;
   } seg_type;

   function automatic logic signed [32:0] sub33(coord_type l, coord_type r);
      return {l[31], l} - {r[31], r};
   endfunction

endpackage
`default_nettype wire

// ===== rtl/svcp_view.sv =====
`default_nettype none
module svcp_view import svcp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    en,
   input  cfg_type cfg,
   input  logic    in_valid,
   input  vec_type in_a,
   input  vec_type in_b,
   input  logic    in_last,
   output logic    out_valid,
   output seg_type out_seg
);

   logic signed [15:0] axis_val [3][3];
   logic signed [32:0] diff_in [2][3];
   logic signed [32:0] diff_ff [2][3];
   logic signed [48:0] prod_in [2][3][3];
   logic signed [48:0] prod_ff [2][3][3];
   coord_type          cam_in [2][3];
   seg_type            seg_in;
   seg_type            seg_ff;
   logic [2:0]         valid_ff;
   logic [1:0]         last_ff;

   // divide by 2^14 toward zero, then clamp to 32 bits
   function automatic coord_type dot_scale(logic signed [50:0] s);
      logic signed [50:0] b;
      logic signed [36:0] q;
      b = s[50] ? s + 51'((1 << AXIS_FRAC) - 1) : s;
      q = 37'(b >>> AXIS_FRAC);
      if (q[36:31] != {6{q[36]}}) begin
         return q[36] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end
      return q[31:0];
   endfunction

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         axis_val[0][c] = cfg.right_axis[16*c +: 16];
         axis_val[1][c] = cfg.up_axis[16*c +: 16];
         axis_val[2][c] = cfg.forward_axis[16*c +: 16];
      end
   end

   always_comb begin
      diff_in[0][0] = sub33(in_a.x, cfg.origin_x);
      diff_in[0][1] = sub33(in_a.y, cfg.origin_y);
      diff_in[0][2] = sub33(in_a.z, cfg.origin_z);
      diff_in[1][0] = sub33(in_b.x, cfg.origin_x);
      diff_in[1][1] = sub33(in_b.y, cfg.origin_y);
      diff_in[1][2] = sub33(in_b.z, cfg.origin_z);
   end

   always_comb begin
      for (int e = 0; e < 2; e++) begin
         for (int k = 0; k < 3; k++) begin
            for (int c = 0; c < 3; c++) begin
               prod_in[e][k][c] = diff_ff[e][c] * axis_val[k][c];
            end
         end
      end
   end

   always_comb begin
      for (int e = 0; e < 2; e++) begin
         for (int k = 0; k < 3; k++) begin
            cam_in[e][k] = dot_scale(51'(prod_ff[e][k][0]) + 51'(prod_ff[e][k][1])
                                     + 51'(prod_ff[e][k][2]));
         end
      end
      seg_in.a.x  = cam_in[0][0];
      seg_in.a.y  = cam_in[0][1];
      seg_in.a.z  = cam_in[0][2];
      seg_in.b.x  = cam_in[1][0];
      seg_in.b.y  = cam_in[1][1];
      seg_in.b.z  = cam_in[1][2];
      seg_in.vis  = 1'b0;
      seg_in.last = last_ff[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         diff_ff <= diff_in;
         prod_ff <= prod_in;
         seg_ff  <= seg_in;
         last_ff <= {last_ff[0], in_last};
      end
   end

   assign out_valid = valid_ff[2];
   assign out_seg   = seg_ff;

endmodule
`default_nettype wire

// ===== rtl/svcp_clip.sv =====
`default_nettype none
module svcp_clip import svcp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic [30:0] near_plane,
   input  logic        in_valid,
   input  seg_type     in_seg,
   output logic        out_valid,
   output seg_type     out_seg
);

   typedef struct packed {
      logic               vis;
      logic               last;
      logic               clip;
      logic               swap;
      vec_type            near_pt;
      vec_type            far_pt;
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic [32:0]        den;
      logic [32:0]        rem;
      logic [CLIP_FRAC-1:0] quot;
      coord_type          near_z;
   } clip_ctx_type;

   typedef struct packed {
      logic               vis;
      logic               last;
      logic               clip;
      logic               swap;
      vec_type            near_pt;
      vec_type            far_pt;
      logic signed [63:0] px;
      logic signed [63:0] py;
      coord_type          near_z;
   } clip_mul_type;

   clip_ctx_type         ctx_ff [CLIP_FRAC+1];
   clip_ctx_type         c0_in;
   logic [CLIP_FRAC:0]   cv_ff;
   clip_mul_type         mul_in;
   clip_mul_type         mul_ff;
   logic                 mv_ff;
   seg_type              fin_in;
   seg_type              fin_ff;
   logic                 fv_ff;
   coord_type            n_val;
   coord_type            xl;
   coord_type            zl;
   logic                 a_near;
   logic                 b_near;
   vec_type              near_sel;
   vec_type              far_sel;
   vec_type              near_new;

   // one restoring step: one bit of the clip factor
   function automatic clip_ctx_type div_step(clip_ctx_type c);
      logic [33:0]  r2;
      clip_ctx_type o;
      o  = c;
      r2 = {c.rem, 1'b0};
      if (r2 >= {1'b0, c.den}) begin
         o.rem  = 33'(r2 - {1'b0, c.den});
         o.quot = {c.quot[CLIP_FRAC-2:0], 1'b1};
      end else begin
         o.rem  = r2[32:0];
         o.quot = {c.quot[CLIP_FRAC-2:0], 1'b0};
      end
      return o;
   endfunction

   function automatic coord_type apply_t(coord_type far_c, logic signed [63:0] p);
      logic signed [63:0] b;
      logic signed [33:0] s;
      b = p[63] ? p + 64'((1 << CLIP_FRAC) - 1) : p;
      s = 34'(b >>> CLIP_FRAC);
      return 32'(s + 34'(far_c));
   endfunction

   always_comb begin
      n_val  = (near_plane == '0) ? 32'sd1 : coord_type'({1'b0, near_plane});
      xl     = coord_type'(X_LIMIT << COORD_FRAC_BITS);
      zl     = coord_type'(Z_LIMIT << COORD_FRAC_BITS);
      a_near = in_seg.a.z < n_val;
      b_near = in_seg.b.z < n_val;
      c0_in.vis  = (in_seg.a.x <= xl || in_seg.b.x <= xl)
                && (in_seg.a.x >= -xl || in_seg.b.x >= -xl)
                && (in_seg.a.z <= zl || in_seg.b.z <= zl)
                && (!a_near || !b_near);
      c0_in.last = in_seg.last;
      c0_in.clip = c0_in.vis && (a_near || b_near);
      c0_in.swap = !a_near;
      near_sel   = a_near ? in_seg.a : in_seg.b;
      far_sel    = a_near ? in_seg.b : in_seg.a;
      c0_in.near_pt = near_sel;
      c0_in.far_pt  = far_sel;
      c0_in.dx      = sub33(near_sel.x, far_sel.x);
      c0_in.dy      = sub33(near_sel.y, far_sel.y);
      c0_in.den     = c0_in.clip ? unsigned'(sub33(far_sel.z, near_sel.z)) : 33'd1;
      c0_in.rem     = c0_in.clip ? unsigned'(sub33(far_sel.z, n_val)) : 33'd0;
      c0_in.quot    = '0;
      c0_in.near_z  = n_val;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctx_ff[0] <= c0_in;
      end
   end

   for (genvar i = 1; i <= CLIP_FRAC; i++) begin : g_div
      always_ff @(posedge clock) begin
         if (en) begin
            ctx_ff[i] <= div_step(ctx_ff[i-1]);
         end
      end
   end

   always_comb begin
      mul_in.vis     = ctx_ff[CLIP_FRAC].vis;
      mul_in.last    = ctx_ff[CLIP_FRAC].last;
      mul_in.clip    = ctx_ff[CLIP_FRAC].clip;
      mul_in.swap    = ctx_ff[CLIP_FRAC].swap;
      mul_in.near_pt = ctx_ff[CLIP_FRAC].near_pt;
      mul_in.far_pt  = ctx_ff[CLIP_FRAC].far_pt;
      mul_in.near_z  = ctx_ff[CLIP_FRAC].near_z;
      mul_in.px = ctx_ff[CLIP_FRAC].dx * $signed({1'b0, ctx_ff[CLIP_FRAC].quot});
      mul_in.py = ctx_ff[CLIP_FRAC].dy * $signed({1'b0, ctx_ff[CLIP_FRAC].quot});
   end

   always_comb begin
      near_new = mul_ff.near_pt;
      if (mul_ff.clip) begin
         near_new.x = apply_t(mul_ff.far_pt.x, mul_ff.px);
         near_new.y = apply_t(mul_ff.far_pt.y, mul_ff.py);
         near_new.z = mul_ff.near_z;
      end
      fin_in.a    = mul_ff.swap ? mul_ff.far_pt : near_new;
      fin_in.b    = mul_ff.swap ? near_new : mul_ff.far_pt;
      fin_in.vis  = mul_ff.vis;
      fin_in.last = mul_ff.last;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mul_ff <= mul_in;
         fin_ff <= fin_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff <= '0;
         mv_ff <= 1'b0;
         fv_ff <= 1'b0;
      end else if (en) begin
         cv_ff <= {cv_ff[CLIP_FRAC-1:0], in_valid};
         mv_ff <= cv_ff[CLIP_FRAC];
         fv_ff <= mv_ff;
      end
   end

   assign out_valid = fv_ff;
   assign out_seg   = fin_ff;

endmodule
`default_nettype wire

// ===== rtl/svcp_proj.sv =====
`default_nettype none
module svcp_proj import svcp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  seg_type     in_seg,
   output logic        out_valid,
   output logic        out_visible,
   output logic [15:0] out_start_col,
   output logic [15:0] out_start_row,
   output logic [15:0] out_end_col,
   output logic [15:0] out_end_row,
   output logic        out_last
);

   typedef struct packed {
      logic                  vis;
      logic                  last;
      logic [3:0]            neg;
      logic [3:0]            ovf;
      logic [3:0][45:0]      rem;
      logic [3:0][QUOT_BITS-1:0] quot;
      logic [1:0][31:0]      den;
   } proj_ctx_type;

   logic signed [45:0] num_in [4];
   logic signed [45:0] num_ff [4];
   coord_type          z_ff [2];
   logic               vis0_ff;
   logic               last0_ff;
   proj_ctx_type       p1_in;
   proj_ctx_type       ctx_ff [QUOT_BITS+1];
   logic [QUOT_BITS+1:0] pv_ff;
   logic [3:0][15:0]   res_in;
   logic [3:0][15:0]   res_ff;
   logic               vis_ff;
   logic               last_ff;
   logic               ov_ff;
   logic [45:0]        mag;

   function automatic proj_ctx_type div_step(proj_ctx_type c, int unsigned bit_pos);
      logic [47:0]  shifted;
      proj_ctx_type o;
      o = c;
      for (int l = 0; l < 4; l++) begin
         shifted = {16'b0, c.den[l/2]} << bit_pos;
         if ({2'b0, c.rem[l]} >= shifted) begin
            o.rem[l]          = c.rem[l] - shifted[45:0];
            o.quot[l][bit_pos] = 1'b1;
         end
      end
      return o;
   endfunction

   function automatic logic [15:0] screen_sat(logic neg, logic ovf,
                                              logic [QUOT_BITS-1:0] q);
      if (neg) begin
         if (ovf || q > 16'd32768) begin
            return 16'h8000;
         end
         return 16'(17'd0 - {1'b0, q});
      end
      if (ovf || q > 16'd32767) begin
         return 16'h7fff;
      end
      return q;
   endfunction

   always_comb begin
      num_in[0] = 46'(CENTER_COL) * 46'(in_seg.a.z) + 46'(SCREEN_SCALE) * 46'(in_seg.a.x);
      num_in[1] = 46'(CENTER_ROW) * 46'(in_seg.a.z) - 46'(SCREEN_SCALE) * 46'(in_seg.a.y);
      num_in[2] = 46'(CENTER_COL) * 46'(in_seg.b.z) + 46'(SCREEN_SCALE) * 46'(in_seg.b.x);
      num_in[3] = 46'(CENTER_ROW) * 46'(in_seg.b.z) - 46'(SCREEN_SCALE) * 46'(in_seg.b.y);
   end

   always_comb begin
      p1_in.vis    = vis0_ff;
      p1_in.last   = last0_ff;
      p1_in.den[0] = z_ff[0];
      p1_in.den[1] = z_ff[1];
      p1_in.quot   = '0;
      mag          = '0;
      for (int l = 0; l < 4; l++) begin
         p1_in.neg[l] = num_ff[l][45];
         mag          = num_ff[l][45] ? unsigned'(-num_ff[l]) : unsigned'(num_ff[l]);
         p1_in.rem[l] = mag;
         p1_in.ovf[l] = {2'b0, mag} >= {z_ff[l/2], 16'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff    <= num_in;
         z_ff[0]   <= in_seg.a.z;
         z_ff[1]   <= in_seg.b.z;
         vis0_ff   <= in_seg.vis;
         last0_ff  <= in_seg.last;
         ctx_ff[0] <= p1_in;
      end
   end

   // one quotient bit per stage, most significant first
   for (genvar k = 1; k <= QUOT_BITS; k++) begin : g_div
      always_ff @(posedge clock) begin
         if (en) begin
            ctx_ff[k] <= div_step(ctx_ff[k-1], QUOT_BITS - k);
         end
      end
   end

   always_comb begin
      for (int l = 0; l < 4; l++) begin
         res_in[l] = ctx_ff[QUOT_BITS].vis
                   ? screen_sat(ctx_ff[QUOT_BITS].neg[l], ctx_ff[QUOT_BITS].ovf[l],
                                ctx_ff[QUOT_BITS].quot[l])
                   : 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff  <= res_in;
         vis_ff  <= ctx_ff[QUOT_BITS].vis;
         last_ff <= ctx_ff[QUOT_BITS].last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= '0;
         ov_ff <= 1'b0;
      end else if (en) begin
         pv_ff <= {pv_ff[QUOT_BITS:0], in_valid};
         ov_ff <= pv_ff[QUOT_BITS+1];
      end
   end

   assign out_valid     = ov_ff;
   assign out_visible   = vis_ff;
   assign out_start_col = res_ff[0];
   assign out_start_row = res_ff[1];
   assign out_end_col   = res_ff[2];
   assign out_end_row   = res_ff[3];
   assign out_last      = last_ff;

endmodule
`default_nettype wire

// ===== rtl/segment_view_clip_project.sv =====
// segment_view_clip_project
// Takes one 3D segment per transfer on the req_ channel (two world endpoints,
// signed Q16.16) and returns one result per segment on the rsp_ channel: the
// visible flag on rsp_tuser, four saturated screen coordinates on rsp_tdata,
// and the segment's last marker on rsp_tlast.
// The csr_ channel writes the camera origin, the three camera axes and the
// near plane; it is always ready and should be written only while idle.
// A segment passes through the camera transform, then the near-plane clip
// (a 30-stage divider makes up most of it), then projection (two 16-stage
// dividers per endpoint), each stage registered.
// Throughput is one segment per cycle while the receiver does not stall;
// every divider and multiplier is fully pipelined.
// When the receiver stalls, the whole pipeline holds and req_tready drops, so
// nothing is lost or repeated; results stay in order.
// Synchronous reset empties the pipeline and loads the default camera:
// origin (0, 0.5, -10), identity axes, near plane 0.5.
`default_nettype none
module segment_view_clip_project import svcp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // start_x, start_y, start_z, end_x, end_y, end_z
   input  logic [191:0] req_tdata,
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // start_col, start_row, end_col, end_row
   output logic [63:0]  rsp_tdata,
   // visible
   output logic [0:0]   rsp_tuser,
   output logic         rsp_tlast,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [47:0]  csr_data
);

   cfg_type     cfg_ff;
   logic        en;
   vec_type     in_a;
   vec_type     in_b;
   logic        view_valid;
   seg_type     view_seg;
   logic        clip_valid;
   seg_type     clip_seg;
   logic        out_valid;
   logic        out_visible;
   logic [15:0] start_col;
   logic [15:0] start_row;
   logic [15:0] end_col;
   logic [15:0] end_row;
   logic        out_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x     <= 32'sd0;
         cfg_ff.origin_y     <= 32'sd32768;
         cfg_ff.origin_z     <= -32'sd655360;
         cfg_ff.right_axis   <= 48'h0000_0000_4000;
         cfg_ff.up_axis      <= 48'h0000_4000_0000;
         cfg_ff.forward_axis <= 48'h4000_0000_0000;
         cfg_ff.near_plane   <= 31'd32768;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_ORIGIN_X: cfg_ff.origin_x     <= csr_data[31:0];
            REG_ORIGIN_Y: cfg_ff.origin_y     <= csr_data[31:0];
            REG_ORIGIN_Z: cfg_ff.origin_z     <= csr_data[31:0];
            REG_RIGHT:    cfg_ff.right_axis   <= csr_data;
            REG_UP:       cfg_ff.up_axis      <= csr_data;
            REG_FORWARD:  cfg_ff.forward_axis <= csr_data;
            REG_NEAR:     cfg_ff.near_plane   <= csr_data[30:0];
            default: begin
            end
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // pipeline moves whenever the output register is free or being drained
   assign en         = !out_valid || rsp_tready;
   assign req_tready = en;

   assign in_a.x = req_tdata[31:0];
   assign in_a.y = req_tdata[63:32];
   assign in_a.z = req_tdata[95:64];
   assign in_b.x = req_tdata[127:96];
   assign in_b.y = req_tdata[159:128];
   assign in_b.z = req_tdata[191:160];

   svcp_view u_view (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_a      (in_a),
      .in_b      (in_b),
      .in_last   (req_tlast),
      .out_valid (view_valid),
      .out_seg   (view_seg)
   );

   svcp_clip u_clip (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .near_plane (cfg_ff.near_plane),
      .in_valid   (view_valid),
      .in_seg     (view_seg),
      .out_valid  (clip_valid),
      .out_seg    (clip_seg)
   );

   svcp_proj u_proj (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .in_valid      (clip_valid),
      .in_seg        (clip_seg),
      .out_valid     (out_valid),
      .out_visible   (out_visible),
      .out_start_col (start_col),
      .out_start_row (start_row),
      .out_end_col   (end_col),
      .out_end_row   (end_row),
      .out_last      (out_last)
   );

   assign rsp_tvalid   = out_valid;
   assign rsp_tdata    = {end_row, end_col, start_row, start_col};
   assign rsp_tuser[0] = out_visible;
   assign rsp_tlast    = out_last;

endmodule
`default_nettype wire
